@@ src/lrfbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lrfbs_pkg
// Types, codes and constants shared by the LCD rectangle fill byte sequencer.
// ----------------------------------------------------------------------------
package lrfbs_pkg;

    // Width of the window coordinates held by the sequencer (8 to 16).
    localparam int COORD_BITS = 16;

    localparam int CFG_INDEX_BITS = 3;

    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // Request operation codes.
    localparam logic [1:0] OP_RECT  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    // Request status codes.
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_BUSY     = 2'd2;

    // Sequencer steps: ten header bytes, the memory write command, then colour.
    localparam logic [3:0] HS_COL_CMD   = 4'd0;
    localparam logic [3:0] HS_XS_HI     = 4'd1;
    localparam logic [3:0] HS_XS_LO     = 4'd2;
    localparam logic [3:0] HS_XE_HI     = 4'd3;
    localparam logic [3:0] HS_XE_LO     = 4'd4;
    localparam logic [3:0] HS_PAGE_CMD  = 4'd5;
    localparam logic [3:0] HS_YS_HI     = 4'd6;
    localparam logic [3:0] HS_YS_LO     = 4'd7;
    localparam logic [3:0] HS_YE_HI     = 4'd8;
    localparam logic [3:0] HS_YE_LO     = 4'd9;
    localparam logic [3:0] HS_MEMWR_CMD = 4'd10;
    localparam logic [3:0] HS_COLOUR    = 4'd11;

    // Configuration register indexes.
    localparam cfg_index_t REG_SCREEN_WIDTH  = 3'd0;
    localparam cfg_index_t REG_SCREEN_HEIGHT = 3'd1;
    localparam cfg_index_t REG_ROW_OFFSET    = 3'd2;
    localparam cfg_index_t REG_COLUMN_CMD    = 3'd3;
    localparam cfg_index_t REG_PAGE_CMD      = 3'd4;
    localparam cfg_index_t REG_MEMWR_CMD     = 3'd5;

    // Configuration reset values.
    localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd128;
    localparam logic [7:0] RST_SCREEN_HEIGHT = 8'd128;
    localparam logic [7:0] RST_ROW_OFFSET    = 8'd32;
    localparam logic [7:0] RST_COLUMN_CMD    = 8'd42;
    localparam logic [7:0] RST_PAGE_CMD      = 8'd43;
    localparam logic [7:0] RST_MEMWR_CMD     = 8'd44;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [15:0] colour;
    } req_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [7:0] screen_width;
        logic [7:0] screen_height;
        logic [7:0] row_offset;
        logic [7:0] column_command;
        logic [7:0] page_command;
        logic [7:0] memory_write_command;
    } cfg_t;

endpackage

@@ src/lrfbs_if.sv @@
// ----------------------------------------------------------------------------
// lrfbs_if
// Request, result and configuration channels of the fill byte sequencer.
// ----------------------------------------------------------------------------
interface lrfbs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] colour;

    modport source
    (
        output valid, op, pos_x, pos_y, rect_width, rect_height, colour,
        input  ready
    );
    modport sink
    (
        input  valid, op, pos_x, pos_y, rect_width, rect_height, colour,
        output ready
    );
endinterface

interface lrfbs_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;

    modport source
    (
        output valid, kind, status, out_byte, is_data, last,
        input  ready
    );
    modport sink
    (
        input  valid, kind, status, out_byte, is_data, last,
        output ready
    );
endinterface

interface lrfbs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lrfbs_pkg::CFG_INDEX_BITS-1:0] index;
    logic [7:0]                       data;

    modport source
    (
        output valid, index, data,
        input  ready
    );
    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

@@ src/lrfbs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lrfbs_cfg_regs
// Configuration register file: screen size, row offset and command bytes.
// ----------------------------------------------------------------------------
module lrfbs_cfg_regs
(
    input  logic             clk,
    input  logic             rst_n,
    lrfbs_cfg_if.sink        cfg,
    output lrfbs_pkg::cfg_t  regs
);

    lrfbs_pkg::cfg_t regs_reg;
    lrfbs_pkg::cfg_t regs_next;
    logic            wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid & cfg.ready;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            case (cfg.index)
                lrfbs_pkg::REG_SCREEN_WIDTH:  regs_next.screen_width         = cfg.data;
                lrfbs_pkg::REG_SCREEN_HEIGHT: regs_next.screen_height        = cfg.data;
                lrfbs_pkg::REG_ROW_OFFSET:    regs_next.row_offset           = cfg.data;
                lrfbs_pkg::REG_COLUMN_CMD:    regs_next.column_command       = cfg.data;
                lrfbs_pkg::REG_PAGE_CMD:      regs_next.page_command         = cfg.data;
                lrfbs_pkg::REG_MEMWR_CMD:     regs_next.memory_write_command = cfg.data;
                default:                      regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.screen_width         <= lrfbs_pkg::RST_SCREEN_WIDTH;
            regs_reg.screen_height        <= lrfbs_pkg::RST_SCREEN_HEIGHT;
            regs_reg.row_offset           <= lrfbs_pkg::RST_ROW_OFFSET;
            regs_reg.column_command       <= lrfbs_pkg::RST_COLUMN_CMD;
            regs_reg.page_command         <= lrfbs_pkg::RST_PAGE_CMD;
            regs_reg.memory_write_command <= lrfbs_pkg::RST_MEMWR_CMD;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ src/lrfbs_engine.sv @@
// ----------------------------------------------------------------------------
// lrfbs_engine
// Clips draw requests, holds the window state and produces at most one status
// or panel byte per registered request.
// ----------------------------------------------------------------------------
module lrfbs_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  lrfbs_pkg::req_t  item,
    input  lrfbs_pkg::cfg_t  cfg,
    output logic             hit,
    output lrfbs_pkg::res_t  result
);

    logic              busy_reg,      busy_next;
    logic [3:0]        step_reg,      step_next;
    lrfbs_pkg::coord_t x_start_reg,   x_start_next;
    lrfbs_pkg::coord_t x_end_reg,     x_end_next;
    lrfbs_pkg::coord_t y_start_reg,   y_start_next;
    lrfbs_pkg::coord_t y_end_reg,     y_end_next;
    logic [15:0]       colour_reg,    colour_next;
    logic [7:0]        cols_left_reg, cols_left_next;
    logic [7:0]        rows_left_reg, rows_left_next;
    logic              low_next_reg,  low_next_next;

    // Clipping of an incoming request.
    lrfbs_pkg::coord_t x_c;
    lrfbs_pkg::coord_t y_c;
    logic [15:0]       x16;
    logic [15:0]       y16;
    logic              off_screen;
    logic [16:0]       x_sum;
    logic [16:0]       y_sum;
    logic              clip_x;
    logic              clip_y;
    logic [15:0]       w_eff;
    logic [15:0]       h_eff;

    // Words sent in the header.
    logic [15:0]       xs_word;
    logic [15:0]       xe_word;
    logic [15:0]       ys_word;
    logic [15:0]       ye_word;
    lrfbs_pkg::coord_t col_reload;

    assign x_c = lrfbs_pkg::coord_t'(item.pos_x);
    assign y_c = lrfbs_pkg::coord_t'(item.pos_y);
    assign x16 = 16'(x_c);
    assign y16 = 16'(y_c);

    assign off_screen = (x16 >= 16'(cfg.screen_width)) || (y16 >= 16'(cfg.screen_height));

    assign x_sum  = 17'(x16) + 17'(item.rect_width) - 17'd1;
    assign y_sum  = 17'(y16) + 17'(item.rect_height) - 17'd1;
    assign clip_x = (item.rect_width != 16'd0) && (x_sum >= 17'(cfg.screen_width));
    assign clip_y = (item.rect_height != 16'd0) && (y_sum >= 17'(cfg.screen_height));
    assign w_eff  = clip_x ? (16'(cfg.screen_width) - x16) : item.rect_width;
    assign h_eff  = clip_y ? (16'(cfg.screen_height) - y16) : item.rect_height;

    assign xs_word = 16'(x_start_reg);
    assign xe_word = 16'(x_end_reg);
    assign ys_word = 16'(y_start_reg + lrfbs_pkg::coord_t'(cfg.row_offset));
    assign ye_word = 16'(y_end_reg + lrfbs_pkg::coord_t'(cfg.row_offset));

    // A row restarts with the full window width.
    assign col_reload = x_end_reg - x_start_reg + lrfbs_pkg::coord_t'(1);

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        x_start_next   = x_start_reg;
        x_end_next     = x_end_reg;
        y_start_next   = y_start_reg;
        y_end_next     = y_end_reg;
        colour_next    = colour_reg;
        cols_left_next = cols_left_reg;
        rows_left_next = rows_left_reg;
        low_next_next  = low_next_reg;
        hit            = 1'b0;
        result         = '0;

        case (item.op)
            lrfbs_pkg::OP_RECT,
            lrfbs_pkg::OP_PIXEL:
            begin
                hit         = 1'b1;
                result.kind = lrfbs_pkg::KIND_STATUS;
                if (busy_reg)
                begin
                    result.status = lrfbs_pkg::ST_BUSY;
                end
                else if (off_screen)
                begin
                    result.status = lrfbs_pkg::ST_DROPPED;
                end
                else
                begin
                    result.status = lrfbs_pkg::ST_ACCEPTED;
                    if (item.op == lrfbs_pkg::OP_RECT)
                    begin
                        x_end_next     = lrfbs_pkg::coord_t'(x16 + w_eff - 16'd1);
                        y_end_next     = lrfbs_pkg::coord_t'(y16 + h_eff - 16'd1);
                        cols_left_next = w_eff[7:0];
                        rows_left_next = h_eff[7:0];
                    end
                    else
                    begin
                        x_end_next     = x_c + lrfbs_pkg::coord_t'(1);
                        y_end_next     = y_c + lrfbs_pkg::coord_t'(1);
                        cols_left_next = 8'd1;
                        rows_left_next = 8'd1;
                    end
                    x_start_next  = x_c;
                    y_start_next  = y_c;
                    colour_next   = item.colour;
                    step_next     = lrfbs_pkg::HS_COL_CMD;
                    low_next_next = 1'b0;
                    busy_next     = 1'b1;
                end
            end

            lrfbs_pkg::OP_TICK:
            begin
                if (busy_reg)
                begin
                    hit            = 1'b1;
                    result.kind    = lrfbs_pkg::KIND_BYTE;
                    result.is_data = 1'b1;
                    step_next      = step_reg + 4'd1;
                    case (step_reg)
                        lrfbs_pkg::HS_COL_CMD:
                        begin
                            result.out_byte = cfg.column_command;
                            result.is_data  = 1'b0;
                        end
                        lrfbs_pkg::HS_XS_HI:  result.out_byte = xs_word[15:8];
                        lrfbs_pkg::HS_XS_LO:  result.out_byte = xs_word[7:0];
                        lrfbs_pkg::HS_XE_HI:  result.out_byte = xe_word[15:8];
                        lrfbs_pkg::HS_XE_LO:  result.out_byte = xe_word[7:0];
                        lrfbs_pkg::HS_PAGE_CMD:
                        begin
                            result.out_byte = cfg.page_command;
                            result.is_data  = 1'b0;
                        end
                        lrfbs_pkg::HS_YS_HI:  result.out_byte = ys_word[15:8];
                        lrfbs_pkg::HS_YS_LO:  result.out_byte = ys_word[7:0];
                        lrfbs_pkg::HS_YE_HI:  result.out_byte = ye_word[15:8];
                        lrfbs_pkg::HS_YE_LO:  result.out_byte = ye_word[7:0];
                        lrfbs_pkg::HS_MEMWR_CMD:
                        begin
                            result.out_byte = cfg.memory_write_command;
                            result.is_data  = 1'b0;
                            // An empty window ends the operation with the command.
                            if ((cols_left_reg == 8'd0) || (rows_left_reg == 8'd0))
                            begin
                                result.last = 1'b1;
                                busy_next   = 1'b0;
                                step_next   = lrfbs_pkg::HS_COL_CMD;
                            end
                        end
                        default:
                        begin
                            step_next = step_reg;
                            if (!low_next_reg)
                            begin
                                result.out_byte = colour_reg[15:8];
                                low_next_next   = 1'b1;
                            end
                            else
                            begin
                                result.out_byte = colour_reg[7:0];
                                low_next_next   = 1'b0;
                                if (cols_left_reg > 8'd1)
                                begin
                                    cols_left_next = cols_left_reg - 8'd1;
                                end
                                else if (rows_left_reg > 8'd1)
                                begin
                                    rows_left_next = rows_left_reg - 8'd1;
                                    cols_left_next = col_reload[7:0];
                                end
                                else
                                begin
                                    result.last    = 1'b1;
                                    cols_left_next = 8'd0;
                                    rows_left_next = 8'd0;
                                    busy_next      = 1'b0;
                                    step_next      = lrfbs_pkg::HS_COL_CMD;
                                end
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= lrfbs_pkg::HS_COL_CMD;
            x_start_reg   <= '0;
            x_end_reg     <= '0;
            y_start_reg   <= '0;
            y_end_reg     <= '0;
            colour_reg    <= '0;
            cols_left_reg <= '0;
            rows_left_reg <= '0;
            low_next_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            x_start_reg   <= x_start_next;
            x_end_reg     <= x_end_next;
            y_start_reg   <= y_start_next;
            y_end_reg     <= y_end_next;
            colour_reg    <= colour_next;
            cols_left_reg <= cols_left_next;
            rows_left_reg <= rows_left_next;
            low_next_reg  <= low_next_next;
        end
    end

    // An idle sequencer always restarts from the column command.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_reg == lrfbs_pkg::HS_COL_CMD) && !low_next_reg)
        else $error("idle sequencer holds a stale step");

    // The low colour byte can only be pending during the colour phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        low_next_reg |-> (step_reg == lrfbs_pkg::HS_COLOUR) && busy_reg)
        else $error("low byte pending outside colour phase");

    // A panel byte is only produced while a drawing operation is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && hit && (result.kind == lrfbs_pkg::KIND_BYTE)) |-> busy_reg)
        else $error("panel byte produced while idle");

    // The final byte of an operation leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && hit && (result.kind == lrfbs_pkg::KIND_BYTE) && result.last)
        |=> !busy_reg)
        else $error("sequencer still busy after the final byte");

endmodule

@@ src/lcd_rect_fill_byte_sequencer.sv @@
// ----------------------------------------------------------------------------
// lcd_rect_fill_byte_sequencer
// A request is held in the input register; its result, if any, in the output register.
// Throughput: one request per cycle unless a result is stalled, set by the single-pass engine stage.
// Reset idles the sequencer, empties both pipeline registers and loads the
// default configuration.
// ----------------------------------------------------------------------------
module lcd_rect_fill_byte_sequencer
(
    input  logic          clk,
    input  logic          rst_n,
    lrfbs_req_if.sink     req,
    lrfbs_res_if.source   res,
    lrfbs_cfg_if.sink     cfg
);

    lrfbs_pkg::cfg_t regs;

    logic            in_valid_reg,  in_valid_next;
    lrfbs_pkg::req_t in_item_reg;
    logic            out_valid_reg, out_valid_next;
    lrfbs_pkg::res_t out_res_reg;

    logic            req_fire;
    logic            advance;
    logic            hit;
    lrfbs_pkg::res_t result;

    lrfbs_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lrfbs_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (regs),
        .hit     (hit),
        .result  (result)
    );

    // The held request moves on whenever the result register can take its output.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    assign in_valid_next  = req_fire || (in_valid_reg && !advance);
    assign out_valid_next = (advance && hit) || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            in_item_reg.op          <= req.op;
            in_item_reg.pos_x       <= req.pos_x;
            in_item_reg.pos_y       <= req.pos_y;
            in_item_reg.rect_width  <= req.rect_width;
            in_item_reg.rect_height <= req.rect_height;
            in_item_reg.colour      <= req.colour;
        end
        if (advance && hit)
        begin
            out_res_reg <= result;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.kind     = out_res_reg.kind;
    assign res.status   = out_res_reg.status;
    assign res.out_byte = out_res_reg.out_byte;
    assign res.is_data  = out_res_reg.is_data;
    assign res.last     = out_res_reg.last;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCD rectangle fill byte sequencer. Draw requests
// and byte-slot ticks are driven with random gaps, register writes without, and
// the result side stalls at random. Every status and panel byte is predicted in
// the bench and checked in order against the result channel.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Not defined by the block; it must be ignored.
    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 190;

    logic clk = 1'b0;
    logic rst_n;

    lrfbs_req_if req_bus ();
    lrfbs_res_if res_bus ();
    lrfbs_cfg_if cfg_bus ();

    lcd_rect_fill_byte_sequencer i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    always #4 clk = ~clk;

    // Expected status and panel bytes, oldest first.
    lrfbs_pkg::res_t pending_panel_out [$];

    int errors;
    int items_sent;
    bit tx_gaps;
    bit rx_gaps;
    bit hold_burst;

    // Predicted copy of the configuration and of the sequencer state.
    lrfbs_pkg::cfg_t   cur_cfg;
    bit                seq_busy;
    logic [3:0]        seq_step;
    lrfbs_pkg::coord_t win_x0;
    lrfbs_pkg::coord_t win_x1;
    lrfbs_pkg::coord_t win_y0;
    lrfbs_pkg::coord_t win_y1;
    logic [15:0]       fill_word;
    logic [7:0]        cols_left;
    logic [7:0]        rows_left;
    bit                low_half;

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic lrfbs_pkg::req_t make_req(input logic [1:0] op,
                                                 input logic [15:0] x,
                                                 input logic [15:0] y,
                                                 input logic [15:0] w,
                                                 input logic [15:0] h,
                                                 input logic [15:0] c);
        lrfbs_pkg::req_t r;
        r.op          = op;
        r.pos_x       = x;
        r.pos_y       = y;
        r.rect_width  = w;
        r.rect_height = h;
        r.colour      = c;
        return r;
    endfunction

    function automatic string res_text(input lrfbs_pkg::res_t r);
        return $sformatf("kind=%0d status=%0d byte=%02h data=%0b last=%0b",
                         r.kind, r.status, r.out_byte, r.is_data, r.last);
    endfunction

    function automatic void apply_register(input lrfbs_pkg::cfg_index_t idx,
                                           input logic [7:0] v);
        case (idx)
            lrfbs_pkg::REG_SCREEN_WIDTH:  cur_cfg.screen_width         = v;
            lrfbs_pkg::REG_SCREEN_HEIGHT: cur_cfg.screen_height        = v;
            lrfbs_pkg::REG_ROW_OFFSET:    cur_cfg.row_offset           = v;
            lrfbs_pkg::REG_COLUMN_CMD:    cur_cfg.column_command       = v;
            lrfbs_pkg::REG_PAGE_CMD:      cur_cfg.page_command         = v;
            lrfbs_pkg::REG_MEMWR_CMD:     cur_cfg.memory_write_command = v;
            default: ;
        endcase
    endfunction

    // Works out what one accepted request produces and moves the predicted
    // sequencer on.
    function automatic void advance_sequencer(input lrfbs_pkg::req_t r);
        lrfbs_pkg::res_t o;
        bit   [31:0]     x;
        bit   [31:0]     y;
        bit   [31:0]     w;
        bit   [31:0]     h;
        bit   [31:0]     t;
        logic [15:0]     xs;
        logic [15:0]     xe;
        logic [15:0]     ya;
        logic [15:0]     yb;
        bit              emit;
        o    = '0;
        emit = 1'b0;
        if (r.op == lrfbs_pkg::OP_RECT || r.op == lrfbs_pkg::OP_PIXEL)
        begin
            emit   = 1'b1;
            o.kind = lrfbs_pkg::KIND_STATUS;
            x      = lrfbs_pkg::coord_t'(r.pos_x);
            y      = lrfbs_pkg::coord_t'(r.pos_y);
            if (seq_busy)
                o.status = lrfbs_pkg::ST_BUSY;
            else if (x >= cur_cfg.screen_width || y >= cur_cfg.screen_height)
                o.status = lrfbs_pkg::ST_DROPPED;
            else
            begin
                o.status = lrfbs_pkg::ST_ACCEPTED;
                if (r.op == lrfbs_pkg::OP_RECT)
                begin
                    w = r.rect_width;
                    h = r.rect_height;
                    if (w != 0 && x + w - 1 >= cur_cfg.screen_width)
                        w = cur_cfg.screen_width - x;
                    if (h != 0 && y + h - 1 >= cur_cfg.screen_height)
                        h = cur_cfg.screen_height - y;
                    win_x1    = lrfbs_pkg::coord_t'(x + w - 1);
                    win_y1    = lrfbs_pkg::coord_t'(y + h - 1);
                    cols_left = w[7:0];
                    rows_left = h[7:0];
                end
                else
                begin
                    win_x1    = lrfbs_pkg::coord_t'(x + 1);
                    win_y1    = lrfbs_pkg::coord_t'(y + 1);
                    cols_left = 8'd1;
                    rows_left = 8'd1;
                end
                win_x0    = lrfbs_pkg::coord_t'(x);
                win_y0    = lrfbs_pkg::coord_t'(y);
                fill_word = r.colour;
                seq_step  = lrfbs_pkg::HS_COL_CMD;
                low_half  = 1'b0;
                seq_busy  = 1'b1;
            end
        end
        else if (r.op == lrfbs_pkg::OP_TICK && seq_busy)
        begin
            emit      = 1'b1;
            o.kind    = lrfbs_pkg::KIND_BYTE;
            o.is_data = 1'b1;
            xs        = win_x0;
            xe        = win_x1;
            t         = win_y0 + cur_cfg.row_offset;
            ya        = lrfbs_pkg::coord_t'(t);
            t         = win_y1 + cur_cfg.row_offset;
            yb        = lrfbs_pkg::coord_t'(t);
            case (seq_step)
                lrfbs_pkg::HS_COL_CMD:
                begin
                    o.out_byte = cur_cfg.column_command;
                    o.is_data  = 1'b0;
                end
                lrfbs_pkg::HS_XS_HI: o.out_byte = xs[15:8];
                lrfbs_pkg::HS_XS_LO: o.out_byte = xs[7:0];
                lrfbs_pkg::HS_XE_HI: o.out_byte = xe[15:8];
                lrfbs_pkg::HS_XE_LO: o.out_byte = xe[7:0];
                lrfbs_pkg::HS_PAGE_CMD:
                begin
                    o.out_byte = cur_cfg.page_command;
                    o.is_data  = 1'b0;
                end
                lrfbs_pkg::HS_YS_HI: o.out_byte = ya[15:8];
                lrfbs_pkg::HS_YS_LO: o.out_byte = ya[7:0];
                lrfbs_pkg::HS_YE_HI: o.out_byte = yb[15:8];
                lrfbs_pkg::HS_YE_LO: o.out_byte = yb[7:0];
                lrfbs_pkg::HS_MEMWR_CMD:
                begin
                    // An empty window ends the operation on this command byte.
                    o.out_byte = cur_cfg.memory_write_command;
                    o.is_data  = 1'b0;
                    o.last     = (cols_left == 0 || rows_left == 0);
                end
                default:
                begin
                    if (!low_half)
                    begin
                        o.out_byte = fill_word[15:8];
                        low_half   = 1'b1;
                    end
                    else
                    begin
                        low_half   = 1'b0;
                        o.out_byte = fill_word[7:0];
                        if (cols_left > 1)
                            cols_left--;
                        else if (rows_left > 1)
                        begin
                            rows_left--;
                            t         = win_x1 - win_x0 + 1;
                            cols_left = t[7:0];
                        end
                        else
                        begin
                            o.last    = 1'b1;
                            cols_left = '0;
                            rows_left = '0;
                            seq_busy  = 1'b0;
                            seq_step  = lrfbs_pkg::HS_COL_CMD;
                        end
                    end
                end
            endcase
            if (seq_busy && seq_step <= lrfbs_pkg::HS_MEMWR_CMD)
            begin
                if (o.last)
                begin
                    seq_busy = 1'b0;
                    seq_step = lrfbs_pkg::HS_COL_CMD;
                end
                else
                    seq_step++;
            end
        end
        if (emit)
            pending_panel_out.push_back(o);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so that a following request needs no toggle.
    task automatic send_request(input lrfbs_pkg::req_t r);
        int n;
        n = tx_gaps ? $urandom_range(0, 11) : 0;
        if (n > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.op          <= r.op;
        req_bus.pos_x       <= r.pos_x;
        req_bus.pos_y       <= r.pos_y;
        req_bus.rect_width  <= r.rect_width;
        req_bus.rect_height <= r.rect_height;
        req_bus.colour      <= r.colour;
        do @(posedge clk); while (!req_bus.ready);
        advance_sequencer(r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_request(make_req(lrfbs_pkg::OP_TICK, rnd16(), rnd16(), rnd16(), rnd16(),
                              rnd16()));
    endtask

    task automatic finish_drawing();
        while (seq_busy)
            send_tick();
    endtask

    // Drops valid, waits for every expected result and lets the pipeline empty.
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (pending_panel_out.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input lrfbs_pkg::cfg_t c);
        lrfbs_pkg::cfg_index_t idx [6];
        logic [7:0]            val [6];
        idx = '{lrfbs_pkg::REG_SCREEN_WIDTH, lrfbs_pkg::REG_SCREEN_HEIGHT,
                lrfbs_pkg::REG_ROW_OFFSET, lrfbs_pkg::REG_COLUMN_CMD,
                lrfbs_pkg::REG_PAGE_CMD, lrfbs_pkg::REG_MEMWR_CMD};
        val = '{c.screen_width, c.screen_height, c.row_offset,
                c.column_command, c.page_command, c.memory_write_command};
        for (int i = 0; i < 6; i++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[i];
            cfg_bus.data  <= val[i];
            do @(posedge clk); while (!cfg_bus.ready);
            apply_register(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic lrfbs_pkg::cfg_t random_cfg();
        lrfbs_pkg::cfg_t c;
        c.screen_width         = 8'($urandom_range(1, 255));
        c.screen_height        = 8'($urandom_range(1, 255));
        c.row_offset           = 8'($urandom_range(0, 255));
        c.column_command       = 8'($urandom_range(0, 255));
        c.page_command         = 8'($urandom_range(0, 255));
        c.memory_write_command = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Chooses an origin on screen and an extent that keeps the fill short:
    // mostly tiny, sometimes a huge extent clipped at the screen edge, else a medium one.
    function automatic void pick_axis(input int lim, output logic [15:0] pos,
                                      output logic [15:0] ext);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 7)
        begin
            pos = 16'($urandom_range(0, lim - 1));
            ext = 16'($urandom_range(0, 3));
        end
        else if (mode < 9)
        begin
            pos = 16'(lim - 1 - $urandom_range(0, (lim > 3) ? 2 : lim - 1));
            ext = rnd16();
        end
        else
        begin
            pos = 16'($urandom_range(0, lim - 1));
            ext = 16'($urandom_range(4, 12));
        end
    endfunction

    // One accepted draw followed by ticks until its last byte, with the odd
    // rejected request or undefined item mixed in.
    task automatic draw_sequence();
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        int          roll;
        pick_axis(cur_cfg.screen_width, x, w);
        pick_axis(cur_cfg.screen_height, y, h);
        send_request(make_req(($urandom_range(0, 9) < 7) ? lrfbs_pkg::OP_RECT
                                                          : lrfbs_pkg::OP_PIXEL,
                              x, y, w, h, rnd16()));
        while (seq_busy)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_request(make_req($urandom_range(0, 1) ? lrfbs_pkg::OP_PIXEL
                                                           : lrfbs_pkg::OP_RECT,
                                      rnd16(), rnd16(), rnd16(), rnd16(), rnd16()));
            else if (roll < 5)
                send_request(make_req(OP_UNDEFINED, rnd16(), rnd16(), rnd16(),
                                      rnd16(), rnd16()));
            else
                send_tick();
        end
    endtask

    // Only sent while idle; draws here always start off screen.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_tick();
            1: send_request(make_req(OP_UNDEFINED, rnd16(), rnd16(), rnd16(),
                                     rnd16(), rnd16()));
            2: send_request(make_req(lrfbs_pkg::OP_RECT,
                                     16'($urandom_range(cur_cfg.screen_width, 65535)),
                                     rnd16(), rnd16(), rnd16(), rnd16()));
            default: send_request(make_req(lrfbs_pkg::OP_PIXEL, rnd16(),
                                     16'($urandom_range(cur_cfg.screen_height, 65535)),
                                     rnd16(), rnd16(), rnd16()));
        endcase
    endtask

    task automatic test_idle_items();
        tx_gaps = 1'b1;
        send_tick();
        send_request(make_req(OP_UNDEFINED, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF));
        settle();
    endtask

    task automatic test_pixel();
        send_request(make_req(lrfbs_pkg::OP_PIXEL, 16'd127, 16'd127, 16'hFFFF,
                              16'hFFFF, 16'hA5C3));
        repeat (3) send_tick();
        send_request(make_req(lrfbs_pkg::OP_RECT, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0));
        finish_drawing();
        settle();
    endtask

    task automatic test_zero_extent();
        // Zero width at the left edge makes the column end wrap round to the top.
        send_request(make_req(lrfbs_pkg::OP_RECT, 16'd0, 16'd0, 16'd0, 16'hFFFF,
                              16'h0000));
        finish_drawing();
        settle();
    endtask

    task automatic test_clipping();
        send_request(make_req(lrfbs_pkg::OP_RECT, 16'd126, 16'd127, 16'hFFFF,
                              16'hFFFF, 16'hFFFF));
        finish_drawing();
        settle();
    endtask

    task automatic test_drops();
        send_request(make_req(lrfbs_pkg::OP_RECT, 16'd128, 16'd0, 16'd1, 16'd1,
                              16'h1234));
        send_request(make_req(lrfbs_pkg::OP_PIXEL, 16'd0, 16'hFFFF, 16'd0, 16'd0,
                              16'h4321));
        settle();
    endtask

    task automatic test_backpressure();
        tx_gaps    = 1'b0;
        hold_burst = 1'b1;
        send_request(make_req(lrfbs_pkg::OP_RECT, 16'd0, 16'd0, 16'd4, 16'd4, rnd16()));
        finish_drawing();
        settle();
        tx_gaps = 1'b1;
    endtask

    task automatic test_zero_screen();
        write_config('{8'd0, 8'd0, 8'hFF, 8'h00, 8'hFF, 8'h00});
        send_request(make_req(lrfbs_pkg::OP_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0,
                              16'hFFFF));
        send_request(make_req(lrfbs_pkg::OP_RECT, 16'd0, 16'd0, 16'd1, 16'd1,
                              16'hFFFF));
        settle();
    endtask

    task automatic test_random_phase(input lrfbs_pkg::cfg_t c, input bit tx_idle,
                                     input bit rx_idle, input int n_items);
        int first;
        write_config(c);
        tx_gaps = tx_idle;
        rx_gaps = rx_idle;
        first   = items_sent;
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(0, 99) < 80)
                draw_sequence();
            else
                send_noise();
        end
        settle();
    endtask

    initial
    begin : result_check
        int              n;
        lrfbs_pkg::res_t got;
        lrfbs_pkg::res_t want;
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = rx_gaps ? $urandom_range(0, 11) : 0;
            if (hold_burst)
            begin
                hold_burst = 1'b0;
                n          = n + LONG_HOLD;
            end
            if (n > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge clk); while (!res_bus.valid);
            got.kind     = res_bus.kind;
            got.status   = res_bus.status;
            got.out_byte = res_bus.out_byte;
            got.is_data  = res_bus.is_data;
            got.last     = res_bus.last;
            if (pending_panel_out.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %s",
                         $time, res_text(got));
                errors++;
            end
            else
            begin
                want = pending_panel_out.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result mismatch, expected %s, actual %s",
                             $time, res_text(want), res_text(got));
                    errors++;
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.op          = lrfbs_pkg::OP_RECT;
        req_bus.pos_x       = '0;
        req_bus.pos_y       = '0;
        req_bus.rect_width  = '0;
        req_bus.rect_height = '0;
        req_bus.colour      = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = lrfbs_pkg::REG_SCREEN_WIDTH;
        cfg_bus.data        = '0;
        errors              = 0;
        items_sent          = 0;
        tx_gaps             = 1'b1;
        rx_gaps             = 1'b1;
        hold_burst          = 1'b0;
        cur_cfg             = '{lrfbs_pkg::RST_SCREEN_WIDTH, lrfbs_pkg::RST_SCREEN_HEIGHT,
                                lrfbs_pkg::RST_ROW_OFFSET, lrfbs_pkg::RST_COLUMN_CMD,
                                lrfbs_pkg::RST_PAGE_CMD, lrfbs_pkg::RST_MEMWR_CMD};
        seq_busy            = 1'b0;
        seq_step            = lrfbs_pkg::HS_COL_CMD;
        win_x0              = '0;
        win_x1              = '0;
        win_y0              = '0;
        win_y1              = '0;
        fill_word           = '0;
        cols_left           = '0;
        rows_left           = '0;
        low_half            = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_items();
        test_pixel();
        test_zero_extent();
        test_clipping();
        test_drops();
        test_backpressure();
        test_zero_screen();
        test_random_phase('{lrfbs_pkg::RST_SCREEN_WIDTH, lrfbs_pkg::RST_SCREEN_HEIGHT,
                            lrfbs_pkg::RST_ROW_OFFSET, lrfbs_pkg::RST_COLUMN_CMD,
                            lrfbs_pkg::RST_PAGE_CMD, lrfbs_pkg::RST_MEMWR_CMD},
                          1'b1, 1'b1, PHASE_ITEMS);
        test_random_phase('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
                          1'b0, 1'b1, PHASE_ITEMS);
        test_random_phase('{8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0},
                          1'b0, 1'b0, PHASE_ITEMS);
        test_random_phase(random_cfg(), 1'b1, 1'b0, PHASE_ITEMS);
        test_random_phase(random_cfg(), 1'b1, 1'b1, PHASE_ITEMS);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
